/* rtl/spkp_pkg.sv */
// Package for the sodium-potassium pump current block.
// Holds the Q16.16 working type, the saturating add and multiply, the exp table
// and the register and status codes. Depends on nothing.
package spkp_pkg;

	typedef logic signed [31:0] fx_t;

	typedef struct packed {
		logic sat;
		fx_t  val;
	} fx_res_t;

	localparam fx_t FX_LIM = 32'sh7FFF_FFFF;
	localparam fx_t FX_ONE = 32'sd65536;
	localparam logic [16:0] FX_LOG2E = 17'd94548;

	localparam logic [16:0] POW2_FRAC [16] = '{
		17'd92682, 17'd77935, 17'd71468, 17'd68438, 17'd66971, 17'd66250, 17'd65892, 17'd65714,
		17'd65625, 17'd65580, 17'd65558, 17'd65547, 17'd65542, 17'd65539, 17'd65537, 17'd65537
	};

	localparam logic [15:0] THERMAL_VOLTAGE_RST = 16'd6838;
	localparam logic [15:0] PUMP_MAX_CURRENT_RST = 16'd6144;
	localparam logic [15:0] POTASSIUM_HALF_SAT_RST = 16'd384;
	localparam logic [15:0] SODIUM_HALF_SAT_RST = 16'd2560;

	typedef enum logic [2:0] {
		REG_THERMAL_VOLTAGE    = 3'd0,
		REG_PUMP_MAX_CURRENT   = 3'd1,
		REG_POTASSIUM_HALF_SAT = 3'd2,
		REG_SODIUM_HALF_SAT    = 3'd3,
		REG_SIGMA_COEFF        = 3'd4,
		REG_RATE_COEFF_LOW     = 3'd5,
		REG_RATE_COEFF_HIGH    = 3'd6
	} reg_index_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	function automatic logic [31:0] fx_mag(fx_t a);
		return a[31] ? 32'(-a) : 32'(a);
	endfunction

	function automatic fx_t q88_s(logic [15:0] f);
		return {{8{f[15]}}, f, 8'd0};
	endfunction

	function automatic fx_t q88_u(logic [15:0] f);
		return {8'd0, f, 8'd0};
	endfunction

	function automatic fx_t q412_s(logic [15:0] f);
		return {{12{f[15]}}, f, 4'd0};
	endfunction

	function automatic fx_t q412_u(logic [15:0] f);
		return {12'd0, f, 4'd0};
	endfunction

	function automatic fx_res_t fx_add(fx_t a, fx_t b);
		logic signed [32:0] s;
		fx_res_t r;
		s = {a[31], a} + {b[31], b};
		if (s > 33'sd2147483647) begin
			r = '{1'b1, FX_LIM};
		end else if (s < -33'sd2147483647) begin
			r = '{1'b1, -FX_LIM};
		end else begin
			r = '{1'b0, s[31:0]};
		end
		return r;
	endfunction

	function automatic fx_res_t fx_mul(fx_t a, fx_t b);
		logic [63:0] p;
		logic [47:0] pm;
		logic neg;
		fx_res_t r;
		p = 64'(fx_mag(a)) * 64'(fx_mag(b));
		pm = p[63:16];
		neg = a[31] ^ b[31];
		if (pm > 48'd2147483647) begin
			r = '{1'b1, neg ? -FX_LIM : FX_LIM};
		end else begin
			r = '{1'b0, neg ? 32'(-pm[31:0]) : pm[31:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/spkp_chan_if.sv */
// Channel interfaces for the sodium-potassium pump current block.
// Item and result channels with valid/ready handshake. Depends on nothing.
interface spkp_item_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] membrane_voltage;
	logic        [15:0] potassium_outside;
	logic        [15:0] sodium_outside;
	logic        [15:0] sodium_inside;
	logic        [15:0] current_gain;

	modport source(output valid, membrane_voltage, potassium_outside, sodium_outside,
		sodium_inside, current_gain, input ready);
	modport sink(input valid, membrane_voltage, potassium_outside, sodium_outside,
		sodium_inside, current_gain, output ready);
endinterface

interface spkp_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pump_current;
	logic        [1:0]  status;

	modport source(output valid, pump_current, status, input ready);
	modport sink(input valid, pump_current, status, output ready);
endinterface

/* rtl/spkp_div.sv */
// Pipelined Q16.16 saturating divider, one quotient bit per stage.
// Carries a sideband vector alongside. Depends on spkp_pkg.
module spkp_div import spkp_pkg::*; #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  fx_t           a,
	input  fx_t           b,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output fx_t           q,
	output logic          sat,
	output logic          zero,
	output logic [SW-1:0] side_o
);

	localparam int STEPS = 31;

	logic          vld_s  [0:STEPS];
	logic [31:0]   rem_s  [0:STEPS];
	logic [30:0]   nlo_s  [0:STEPS];
	logic [30:0]   quo_s  [0:STEPS];
	logic [31:0]   dvs_s  [0:STEPS];
	logic          neg_s  [0:STEPS];
	logic          zero_s [0:STEPS];
	logic          ovf_s  [0:STEPS];
	logic [SW-1:0] side_s [0:STEPS];

	logic [31:0] ma;
	logic [31:0] mb;

	assign ma = fx_mag(a);
	assign mb = fx_mag(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {15'd0, ma[31:15]};
			nlo_s[0]  <= {ma[14:0], 16'd0};
			quo_s[0]  <= '0;
			dvs_s[0]  <= mb;
			neg_s[0]  <= a[31] ^ b[31];
			zero_s[0] <= (b == '0);
			ovf_s[0]  <= ({15'd0, ma} >= {mb, 15'd0});
			side_s[0] <= side_i;
		end
	end

	for (genvar i = 1; i <= STEPS; i++) begin : g_step
		logic [32:0] sh;
		logic [32:0] trial;
		logic        ge;

		assign sh    = {rem_s[i-1], nlo_s[i-1][30]};
		assign trial = sh - {1'b0, dvs_s[i-1]};
		assign ge    = !trial[32];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? trial[31:0] : sh[31:0];
				nlo_s[i]  <= {nlo_s[i-1][29:0], 1'b0};
				quo_s[i]  <= {quo_s[i-1][29:0], ge};
				dvs_s[i]  <= dvs_s[i-1];
				neg_s[i]  <= neg_s[i-1];
				zero_s[i] <= zero_s[i-1];
				ovf_s[i]  <= ovf_s[i-1];
				side_s[i] <= side_s[i-1];
			end
		end
	end

	logic [30:0] qv;

	always_comb begin
		if (zero_s[STEPS]) begin
			qv = '0;
		end else if (ovf_s[STEPS]) begin
			qv = '1;
		end else begin
			qv = quo_s[STEPS];
		end
	end

	assign vld_o  = vld_s[STEPS];
	assign q      = neg_s[STEPS] ? -fx_t'({1'b0, qv}) : fx_t'({1'b0, qv});
	assign sat    = ovf_s[STEPS] && !zero_s[STEPS];
	assign zero   = zero_s[STEPS];
	assign side_o = side_s[STEPS];

endmodule

/* rtl/spkp_exp.sv */
// Pipelined Q16.16 exp: base-two range reduction and a product of table
// entries, one table multiply per stage. Depends on spkp_pkg.
module spkp_exp import spkp_pkg::*; #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  fx_t           x,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output fx_t           y,
	output logic          sat,
	output logic [SW-1:0] side_o
);

	localparam int TERMS = 16;

	logic               vld_t_q;
	logic signed [33:0] t_q;
	logic [SW-1:0]      side_t_q;

	logic [48:0] tp;
	logic [32:0] tm;

	assign tp = 49'(fx_mag(x)) * 49'(FX_LOG2E);
	assign tm = tp[48:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t_q <= 1'b0;
		end else if (en) begin
			vld_t_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_q      <= x[31] ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
			side_t_q <= side_i;
		end
	end

	logic              vld_s  [0:TERMS];
	logic [16:0]       m_s    [0:TERMS];
	logic [15:0]       f_s    [0:TERMS];
	logic signed [6:0] k_s    [0:TERMS];
	logic              big_s  [0:TERMS];
	logic              tiny_s [0:TERMS];
	logic [SW-1:0]     side_s [0:TERMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_t_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= 17'd65536;
			f_s[0]    <= t_q[15:0];
			k_s[0]    <= t_q[22:16];
			big_s[0]  <= (t_q >= 34'sd983040);
			tiny_s[0] <= (t_q < -34'sd2621440);
			side_s[0] <= side_t_q;
		end
	end

	for (genvar j = 1; j <= TERMS; j++) begin : g_term
		logic [33:0] prod;

		assign prod = 34'(m_s[j-1]) * 34'(POW2_FRAC[j-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[j]    <= f_s[j-1][TERMS-j] ? prod[32:16] : m_s[j-1];
				f_s[j]    <= f_s[j-1];
				k_s[j]    <= k_s[j-1];
				big_s[j]  <= big_s[j-1];
				tiny_s[j] <= tiny_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	logic          vld_o_q;
	fx_t           y_q;
	logic          sat_q;
	logic [SW-1:0] side_o_q;
	fx_t           y_d;
	logic [6:0]    nk;

	assign nk = 7'(-k_s[TERMS]);

	always_comb begin
		if (big_s[TERMS]) begin
			y_d = FX_LIM;
		end else if (tiny_s[TERMS]) begin
			y_d = '0;
		end else if (!k_s[TERMS][6]) begin
			y_d = fx_t'(32'(m_s[TERMS]) << k_s[TERMS][3:0]);
		end else begin
			y_d = fx_t'(32'(m_s[TERMS]) >> nk[5:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_q <= 1'b0;
		end else if (en) begin
			vld_o_q <= vld_s[TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_q      <= y_d;
			sat_q    <= big_s[TERMS];
			side_o_q <= side_s[TERMS];
		end
	end

	assign vld_o  = vld_o_q;
	assign y      = y_q;
	assign sat    = sat_q;
	assign side_o = side_o_q;

endmodule

/* rtl/sodium_potassium_pump_current.sv */
// Sodium-potassium pump current, fully pipelined Q16.16 datapath.
// Accepts one item per cycle unless a held result with result.ready low stalls the
// pipeline. It runs five 32-stage dividers and a 19-stage exp chain in series.
// Asynchronous active-low reset clears all valid bits and loads configuration defaults.
module sodium_potassium_pump_current import spkp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_write,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	spkp_item_if.sink    item,
	spkp_result_if.source result
);

	typedef struct packed {
		fx_t  ko;
		fx_t  gain;
		logic sat;
	} side_a_t;

	typedef struct packed {
		fx_t  x;
		fx_t  m;
		fx_t  r;
		fx_t  n;
		fx_t  ko;
		fx_t  gain;
		logic sat;
		logic zero;
	} side_b_t;

	typedef struct packed {
		fx_t  r;
		fx_t  n;
		fx_t  ko;
		fx_t  gain;
		logic sat;
		logic zero;
	} side_c_t;

	typedef struct packed {
		fx_t  e1;
		fx_t  e2;
		fx_t  r;
		fx_t  n;
		fx_t  ko;
		fx_t  gain;
		logic sat;
		logic zero;
	} side_d_t;

	typedef struct packed {
		fx_t  d;
		fx_t  ko;
		fx_t  gain;
		logic sat;
		logic zero;
	} side_e_t;

	typedef struct packed {
		logic sat;
		logic zero;
	} side_f_t;

	logic [15:0] tv_q, imax_q, kmk_q, kmna_q;
	logic [63:0] sig_q, rlo_q, rhi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_q   <= THERMAL_VOLTAGE_RST;
			imax_q <= PUMP_MAX_CURRENT_RST;
			kmk_q  <= POTASSIUM_HALF_SAT_RST;
			kmna_q <= SODIUM_HALF_SAT_RST;
			sig_q  <= '0;
			rlo_q  <= '0;
			rhi_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THERMAL_VOLTAGE:    tv_q   <= cfg_data[15:0];
				REG_PUMP_MAX_CURRENT:   imax_q <= cfg_data[15:0];
				REG_POTASSIUM_HALF_SAT: kmk_q  <= cfg_data[15:0];
				REG_SODIUM_HALF_SAT:    kmna_q <= cfg_data[15:0];
				REG_SIGMA_COEFF:        sig_q  <= cfg_data;
				REG_RATE_COEFF_LOW:     rlo_q  <= cfg_data;
				REG_RATE_COEFF_HIGH:    rhi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	fx_t rtf, imax, kmk, kmna;
	fx_t a0, a1, a2, a3, b0, b11, b12, b13, b21, b22, b23, b3;

	assign rtf  = q88_u(tv_q);
	assign imax = q412_u(imax_q);
	assign kmk  = q88_u(kmk_q);
	assign kmna = q88_u(kmna_q);
	assign a0   = q88_s(sig_q[15:0]);
	assign a1   = q88_s(sig_q[31:16]);
	assign a2   = q88_s(sig_q[47:32]);
	assign a3   = q88_s(sig_q[63:48]);
	assign b0   = q412_s(rlo_q[15:0]);
	assign b11  = q412_s(rlo_q[31:16]);
	assign b12  = q412_s(rlo_q[47:32]);
	assign b13  = q412_s(rlo_q[63:48]);
	assign b21  = q412_s(rhi_q[15:0]);
	assign b22  = q412_s(rhi_q[31:16]);
	assign b23  = q412_s(rhi_q[47:32]);
	assign b3   = q412_s(rhi_q[63:48]);

	logic en;
	logic vld_s14;

	assign en         = !vld_s14 || result.ready;
	assign item.ready = en;

	// input capture
	logic vld_s1;
	fx_t  v_s1, ko_s1, nao_s1, nai_s1, gain_s1;

	// sodium offset and voltage offsets
	logic vld_s2, sat_s2;
	fx_t  addn_s2, add1_s2, add2_s2, ko_s2, nai_s2, gain_s2;
	fx_res_t r_addn, r_add1, r_add2;

	assign r_addn = fx_add(nao_s1, a2);
	assign r_add1 = fx_add(v_s1, b12);
	assign r_add2 = fx_add(v_s1, b22);

	// first slope
	logic vld_s3, sat_s3;
	fx_t  addn_s3, m1_s3, add2_s3, ko_s3, nai_s3, gain_s3;
	fx_res_t r_m1;

	assign r_m1 = fx_mul(add1_s2, b13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1    <= q88_s(item.membrane_voltage);
			ko_s1   <= q88_u(item.potassium_outside);
			nao_s1  <= q88_u(item.sodium_outside);
			nai_s1  <= q88_u(item.sodium_inside);
			gain_s1 <= q412_u(item.current_gain);

			addn_s2 <= r_addn.val;
			add1_s2 <= r_add1.val;
			add2_s2 <= r_add2.val;
			ko_s2   <= ko_s1;
			nai_s2  <= nai_s1;
			gain_s2 <= gain_s1;
			sat_s2  <= r_addn.sat | r_add1.sat | r_add2.sat;

			addn_s3 <= addn_s2;
			m1_s3   <= r_m1.val;
			add2_s3 <= add2_s2;
			ko_s3   <= ko_s2;
			nai_s3  <= nai_s2;
			gain_s3 <= gain_s2;
			sat_s3  <= sat_s2 | r_m1.sat;
		end
	end

	// first divider bank
	side_a_t sa_i, sa_o;
	logic    vld_a;
	fx_t     qa_x, qa_m, qa_p, qa_r, qa_n;
	logic    sa_x, sa_m, sa_p, sa_r, sa_n;
	logic    za_x, za_m, za_p, za_r, za_n;

	assign sa_i = '{ko: ko_s3, gain: gain_s3, sat: sat_s3};

	spkp_div #(.SW($bits(side_a_t))) u_div_x (
		.clk, .arst_n, .en, .vld_i(vld_s3), .a(addn_s3), .b(a3), .side_i(sa_i),
		.vld_o(vld_a), .q(qa_x), .sat(sa_x), .zero(za_x), .side_o(sa_o)
	);

	spkp_div #(.SW(1)) u_div_m (
		.clk, .arst_n, .en, .vld_i(vld_s3), .a(m1_s3), .b(rtf), .side_i(1'b0),
		.vld_o(), .q(qa_m), .sat(sa_m), .zero(za_m), .side_o()
	);

	spkp_div #(.SW(1)) u_div_p (
		.clk, .arst_n, .en, .vld_i(vld_s3), .a(add2_s3), .b(b23), .side_i(1'b0),
		.vld_o(), .q(qa_p), .sat(sa_p), .zero(za_p), .side_o()
	);

	spkp_div #(.SW(1)) u_div_r (
		.clk, .arst_n, .en, .vld_i(vld_s3), .a(FX_ONE), .b(a0), .side_i(1'b0),
		.vld_o(), .q(qa_r), .sat(sa_r), .zero(za_r), .side_o()
	);

	spkp_div #(.SW(1)) u_div_n (
		.clk, .arst_n, .en, .vld_i(vld_s3), .a(kmna), .b(nai_s3), .side_i(1'b0),
		.vld_o(), .q(qa_n), .sat(sa_n), .zero(za_n), .side_o()
	);

	logic    vld_s4;
	fx_t     p_s4;
	side_b_t sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4 <= qa_p;
			sb_s4 <= '{x: qa_x, m: qa_m, r: qa_r, n: qa_n, ko: sa_o.ko, gain: sa_o.gain,
				sat: sa_o.sat | sa_x | sa_m | sa_p | sa_r | sa_n,
				zero: za_x | za_m | za_p | za_r | za_n};
		end
	end

	// second voltage divide
	side_b_t sb_o;
	logic    vld_b;
	fx_t     qb;
	logic    sat_b, zero_b;

	spkp_div #(.SW($bits(side_b_t))) u_div_v (
		.clk, .arst_n, .en, .vld_i(vld_s4), .a(p_s4), .b(rtf), .side_i(sb_s4),
		.vld_o(vld_b), .q(qb), .sat(sat_b), .zero(zero_b), .side_o(sb_o)
	);

	// exp bank
	side_c_t sc_i, sc_o;
	logic    vld_c;
	fx_t     ex_y, e1_y, e2_y;
	logic    ex_sat, e1_sat, e2_sat;

	assign sc_i = '{r: sb_o.r, n: sb_o.n, ko: sb_o.ko, gain: sb_o.gain,
		sat: sb_o.sat | sat_b, zero: sb_o.zero | zero_b};

	spkp_exp #(.SW($bits(side_c_t))) u_exp_x (
		.clk, .arst_n, .en, .vld_i(vld_b), .x(sb_o.x), .side_i(sc_i),
		.vld_o(vld_c), .y(ex_y), .sat(ex_sat), .side_o(sc_o)
	);

	spkp_exp #(.SW(1)) u_exp_1 (
		.clk, .arst_n, .en, .vld_i(vld_b), .x(sb_o.m), .side_i(1'b0),
		.vld_o(), .y(e1_y), .sat(e1_sat), .side_o()
	);

	spkp_exp #(.SW(1)) u_exp_2 (
		.clk, .arst_n, .en, .vld_i(vld_b), .x(qb), .side_i(1'b0),
		.vld_o(), .y(e2_y), .sat(e2_sat), .side_o()
	);

	logic    vld_s5;
	fx_t     ex_s5;
	side_d_t sd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s5 <= ex_y;
			sd_s5 <= '{e1: e1_y, e2: e2_y, r: sc_o.r, n: sc_o.n, ko: sc_o.ko, gain: sc_o.gain,
				sat: sc_o.sat | ex_sat | e1_sat | e2_sat, zero: sc_o.zero};
		end
	end

	// sigma scale divide
	side_d_t sd_o;
	logic    vld_d;
	fx_t     qd;
	logic    sat_d, zero_d;

	spkp_div #(.SW($bits(side_d_t))) u_div_s (
		.clk, .arst_n, .en, .vld_i(vld_s5), .a(ex_s5), .b(a1), .side_i(sd_s5),
		.vld_o(vld_d), .q(qd), .sat(sat_d), .zero(zero_d), .side_o(sd_o)
	);

	fx_res_t r_sigma, r_rr;

	assign r_sigma = fx_add(sd_o.r, qd);
	assign r_rr    = fx_mul(sd_o.n, sd_o.n);

	logic vld_s6, sat_s6, zero_s6;
	fx_t  sigma_s6, rr_s6, e1_s6, e2_s6, ko_s6, gain_s6;

	fx_res_t r_t1, r_t2a, r_dd, r_kk;

	assign r_t1  = fx_mul(b11, e1_s6);
	assign r_t2a = fx_mul(b21, sigma_s6);
	assign r_dd  = fx_add(FX_ONE, rr_s6);
	assign r_kk  = fx_add(ko_s6, kmk);

	logic vld_s7, sat_s7, zero_s7;
	fx_t  t1_s7, t2a_s7, dd_s7, kk_s7, e2_s7, ko_s7, gain_s7;

	fx_res_t r_t2, r_d;

	assign r_t2 = fx_mul(t2a_s7, e2_s7);
	assign r_d  = fx_mul(kk_s7, dd_s7);

	logic vld_s8, sat_s8, zero_s8;
	fx_t  t1_s8, t2_s8, d_s8, ko_s8, gain_s8;

	fx_res_t r_den0;

	assign r_den0 = fx_add(t1_s8, t2_s8);

	logic vld_s9, sat_s9, zero_s9;
	fx_t  den0_s9, d_s9, ko_s9, gain_s9;

	fx_res_t r_den;

	assign r_den = fx_add(den0_s9, b3);

	logic    vld_s10;
	fx_t     den_s10;
	side_e_t se_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s6  <= vld_d;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sigma_s6 <= r_sigma.val;
			rr_s6    <= r_rr.val;
			e1_s6    <= sd_o.e1;
			e2_s6    <= sd_o.e2;
			ko_s6    <= sd_o.ko;
			gain_s6  <= sd_o.gain;
			sat_s6   <= sd_o.sat | sat_d | r_sigma.sat | r_rr.sat;
			zero_s6  <= sd_o.zero | zero_d;

			t1_s7   <= r_t1.val;
			t2a_s7  <= r_t2a.val;
			dd_s7   <= r_dd.val;
			kk_s7   <= r_kk.val;
			e2_s7   <= e2_s6;
			ko_s7   <= ko_s6;
			gain_s7 <= gain_s6;
			sat_s7  <= sat_s6 | r_t1.sat | r_t2a.sat | r_dd.sat | r_kk.sat;
			zero_s7 <= zero_s6;

			t1_s8   <= t1_s7;
			t2_s8   <= r_t2.val;
			d_s8    <= r_d.val;
			ko_s8   <= ko_s7;
			gain_s8 <= gain_s7;
			sat_s8  <= sat_s7 | r_t2.sat | r_d.sat;
			zero_s8 <= zero_s7;

			den0_s9 <= r_den0.val;
			d_s9    <= d_s8;
			ko_s9   <= ko_s8;
			gain_s9 <= gain_s8;
			sat_s9  <= sat_s8 | r_den0.sat;
			zero_s9 <= zero_s8;

			den_s10 <= r_den.val;
			se_s10  <= '{d: d_s9, ko: ko_s9, gain: gain_s9, sat: sat_s9 | r_den.sat,
				zero: zero_s9};
		end
	end

	// rate factor divide
	side_e_t se_o;
	logic    vld_e;
	fx_t     qe;
	logic    sat_e, zero_e;

	spkp_div #(.SW($bits(side_e_t))) u_div_f (
		.clk, .arst_n, .en, .vld_i(vld_s10), .a(b0), .b(den_s10), .side_i(se_s10),
		.vld_o(vld_e), .q(qe), .sat(sat_e), .zero(zero_e), .side_o(se_o)
	);

	fx_res_t r_n1;

	assign r_n1 = fx_mul(imax, qe);

	logic vld_s11, sat_s11, zero_s11;
	fx_t  n1_s11, d_s11, ko_s11, gain_s11;

	fx_res_t r_num;

	assign r_num = fx_mul(n1_s11, ko_s11);

	logic vld_s12, sat_s12, zero_s12;
	fx_t  num_s12, d_s12, gain_s12;

	fx_res_t r_gn;

	assign r_gn = fx_mul(gain_s12, num_s12);

	logic    vld_s13;
	fx_t     gn_s13, d_s13;
	side_f_t sf_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_e;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s11   <= r_n1.val;
			d_s11    <= se_o.d;
			ko_s11   <= se_o.ko;
			gain_s11 <= se_o.gain;
			sat_s11  <= se_o.sat | sat_e | r_n1.sat;
			zero_s11 <= se_o.zero | zero_e;

			num_s12  <= r_num.val;
			d_s12    <= d_s11;
			gain_s12 <= gain_s11;
			sat_s12  <= sat_s11 | r_num.sat;
			zero_s12 <= zero_s11;

			gn_s13 <= r_gn.val;
			d_s13  <= d_s12;
			sf_s13 <= '{sat: sat_s12 | r_gn.sat, zero: zero_s12};
		end
	end

	// final divide
	side_f_t sf_o;
	logic    vld_f;
	fx_t     qf;
	logic    sat_f, zero_f;

	spkp_div #(.SW($bits(side_f_t))) u_div_o (
		.clk, .arst_n, .en, .vld_i(vld_s13), .a(gn_s13), .b(d_s13), .side_i(sf_s13),
		.vld_o(vld_f), .q(qf), .sat(sat_f), .zero(zero_f), .side_o(sf_o)
	);

	// Q16.16 to Q4.12 with truncation toward zero and saturation
	logic [31:0]        qf_mag;
	logic [27:0]        m4;
	logic               neg_f;
	logic               osat;
	logic signed [15:0] cur_d;
	logic [1:0]         st_d;

	assign qf_mag = fx_mag(qf);
	assign m4     = qf_mag[31:4];
	assign neg_f  = qf[31];

	always_comb begin
		osat = 1'b0;
		if (!neg_f && m4 > 28'd32767) begin
			osat  = 1'b1;
			cur_d = 16'sh7FFF;
		end else if (neg_f && m4 > 28'd32768) begin
			osat  = 1'b1;
			cur_d = 16'sh8000;
		end else begin
			cur_d = neg_f ? 16'(-m4[15:0]) : m4[15:0];
		end
		if (sf_o.zero || zero_f) begin
			cur_d = '0;
			st_d  = ST_ZERO;
		end else if (sf_o.sat || sat_f || osat) begin
			st_d = ST_SAT;
		end else begin
			st_d = ST_OK;
		end
	end

	logic signed [15:0] cur_s14;
	logic [1:0]         st_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s14 <= vld_f;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_s14 <= cur_d;
			st_s14  <= st_d;
		end
	end

	assign result.valid        = vld_s14;
	assign result.pump_current = cur_s14;
	assign result.status       = st_s14;

endmodule

/* tb/sv/tb_sodium_potassium_pump_current.sv */
// Testbench for sodium_potassium_pump_current: streams items and checks each pump
// current and status against a Q16.16 predictor kept in a small scoreboard class.
// Depends on spkp_pkg, spkp_chan_if.sv and the block itself.
module tb_sodium_potassium_pump_current;
	import spkp_pkg::*;

	localparam int IDLE_LIMIT = 6000;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct {
		logic signed [15:0] v;
		logic [15:0] ko;
		logic [15:0] nao;
		logic [15:0] nai;
		logic [15:0] gain;
	} pump_item_t;

	typedef struct {
		logic signed [15:0] current;
		logic [1:0] status;
	} pump_result_t;

	class pump_scoreboard;
		longint tv, imax_q, kmk_q, kmna_q;
		bit [63:0] sigma_w, rate_lo_w, rate_hi_w;
		bit sat_flag, zero_flag;
		pump_result_t expected_currents[$];
		int errors;

		function new();
			reset_regs();
			errors = 0;
		endfunction

		function void reset_regs();
			tv = THERMAL_VOLTAGE_RST;
			imax_q = PUMP_MAX_CURRENT_RST;
			kmk_q = POTASSIUM_HALF_SAT_RST;
			kmna_q = SODIUM_HALF_SAT_RST;
			sigma_w = '0;
			rate_lo_w = '0;
			rate_hi_w = '0;
		endfunction

		function void write_reg(reg_index_t idx, bit [63:0] d);
			case (idx)
				REG_THERMAL_VOLTAGE:    tv = d[15:0];
				REG_PUMP_MAX_CURRENT:   imax_q = d[15:0];
				REG_POTASSIUM_HALF_SAT: kmk_q = d[15:0];
				REG_SODIUM_HALF_SAT:    kmna_q = d[15:0];
				REG_SIGMA_COEFF:        sigma_w = d;
				REG_RATE_COEFF_LOW:     rate_lo_w = d;
				REG_RATE_COEFF_HIGH:    rate_hi_w = d;
				default: ;
			endcase
		endfunction

		function longint clamp(longint x);
			if (x > 64'sd2147483647) begin
				sat_flag = 1;
				return 64'sd2147483647;
			end
			if (x < -64'sd2147483647) begin
				sat_flag = 1;
				return -64'sd2147483647;
			end
			return x;
		endfunction

		function longint magn(longint x);
			return x < 0 ? -x : x;
		endfunction

		function longint mul_trunc(longint a, longint b);
			longint p;
			p = (magn(a) * magn(b)) >> 16;
			return ((a < 0) != (b < 0)) ? -p : p;
		endfunction

		function longint qmul(longint a, longint b);
			return clamp(mul_trunc(a, b));
		endfunction

		function longint qadd(longint a, longint b);
			return clamp(a + b);
		endfunction

		function longint qdiv(longint a, longint b);
			longint q;
			if (b == 0) begin
				zero_flag = 1;
				return 0;
			end
			q = (magn(a) << 16) / magn(b);
			if (q > 64'sd2147483647) begin
				sat_flag = 1;
				q = 64'sd2147483647;
			end
			return ((a < 0) != (b < 0)) ? -q : q;
		endfunction

		function longint qexp(longint x);
			longint t, k, f, m;
			t = mul_trunc(x, longint'(FX_LOG2E));
			m = 65536;
			if (t >= 15 * 65536) begin
				sat_flag = 1;
				return 64'sd2147483647;
			end
			if (t < -40 * 65536)
				return 0;
			if (t >= 0) k = t / 65536;
			else k = -((-t + 65535) / 65536);
			f = t - k * 65536;
			for (int j = 0; j < 16; j++) begin
				if ((f >> (15 - j)) & 1)
					m = (m * longint'(POW2_FRAC[j])) >> 16;
			end
			if (k >= 0) m = m << k;
			else m = m >> (-k);
			return clamp(m);
		endfunction

		function longint sfield(bit [63:0] w, int pos);
			return longint'($signed(w[16*pos +: 16]));
		endfunction

		function pump_result_t predict_current(pump_item_t it);
			longint v, ko, nao, nai, gain, rtf, imax, kmk, kmna;
			longint a0, a1, a2, a3, b0, b11, b12, b13, b21, b22, b23, b3;
			longint sigma, e1, e2, den, fr, num, d, ratio, res;
			pump_result_t r;
			sat_flag = 0;
			zero_flag = 0;
			v = longint'(it.v) * 256;
			ko = longint'(it.ko) * 256;
			nao = longint'(it.nao) * 256;
			nai = longint'(it.nai) * 256;
			gain = longint'(it.gain) * 16;
			rtf = tv * 256;
			imax = imax_q * 16;
			kmk = kmk_q * 256;
			kmna = kmna_q * 256;
			a0 = sfield(sigma_w, 0) * 256;
			a1 = sfield(sigma_w, 1) * 256;
			a2 = sfield(sigma_w, 2) * 256;
			a3 = sfield(sigma_w, 3) * 256;
			b0 = sfield(rate_lo_w, 0) * 16;
			b11 = sfield(rate_lo_w, 1) * 16;
			b12 = sfield(rate_lo_w, 2) * 16;
			b13 = sfield(rate_lo_w, 3) * 16;
			b21 = sfield(rate_hi_w, 0) * 16;
			b22 = sfield(rate_hi_w, 1) * 16;
			b23 = sfield(rate_hi_w, 2) * 16;
			b3 = sfield(rate_hi_w, 3) * 16;

			sigma = qadd(qdiv(65536, a0), qdiv(qexp(qdiv(qadd(nao, a2), a3)), a1));
			e1 = qexp(qdiv(qmul(qadd(v, b12), b13), rtf));
			e2 = qexp(qdiv(qdiv(qadd(v, b22), b23), rtf));
			den = qadd(qadd(qmul(b11, e1), qmul(qmul(b21, sigma), e2)), b3);
			fr = qdiv(b0, den);
			num = qmul(qmul(imax, fr), ko);
			ratio = qdiv(kmna, nai);
			d = qmul(qadd(ko, kmk), qadd(65536, qmul(ratio, ratio)));
			res = qdiv(qmul(gain, num), d);

			res = res < 0 ? -(magn(res) >> 4) : (res >> 4);
			if (res > 32767) begin
				sat_flag = 1;
				res = 32767;
			end
			if (res < -32768) begin
				sat_flag = 1;
				res = -32768;
			end
			r.current = res[15:0];
			r.status = ST_OK;
			if (zero_flag) begin
				r.current = '0;
				r.status = ST_ZERO;
			end else if (sat_flag) begin
				r.status = ST_SAT;
			end
			return r;
		endfunction

		function void note_item(pump_item_t it);
			expected_currents.push_back(predict_current(it));
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		endtask

		task check_result(logic signed [15:0] current, logic [1:0] status);
			pump_result_t e;
			if (expected_currents.size() == 0) begin
				report("unexpected result, current", current, 0);
				return;
			end
			e = expected_currents.pop_front();
			if (current !== e.current)
				report("pump_current", current, e.current);
			if (status !== e.status)
				report("status", status, e.status);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;
	int idle_cycles;

	spkp_item_if item();
	spkp_result_if result();

	pump_scoreboard sb = new();

	sodium_potassium_pump_current u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item.sink),
		.result(result.source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (item.valid && item.ready) begin
				pump_item_t it;
				it.v = item.membrane_voltage;
				it.ko = item.potassium_outside;
				it.nao = item.sodium_outside;
				it.nai = item.sodium_inside;
				it.gain = item.current_gain;
				sb.note_item(it);
			end
			if (result.valid && result.ready)
				sb.check_result(result.pump_current, result.status);
			if ((item.valid && item.ready) || (result.valid && result.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL sodium_potassium_pump_current");
				$finish;
			end
		end
	end

	initial begin
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int run, stall;
			run = $urandom_range(1, 30);
			stall = gap_len();
			result.ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	task write_cfg(reg_index_t idx, logic [63:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	task write_all(logic [15:0] tv, logic [15:0] imax, logic [15:0] kmk, logic [15:0] kmna,
			logic [63:0] sig, logic [63:0] lo, logic [63:0] hi);
		write_cfg(REG_THERMAL_VOLTAGE, {48'd0, tv});
		write_cfg(REG_PUMP_MAX_CURRENT, {48'd0, imax});
		write_cfg(REG_POTASSIUM_HALF_SAT, {48'd0, kmk});
		write_cfg(REG_SODIUM_HALF_SAT, {48'd0, kmna});
		write_cfg(REG_SIGMA_COEFF, sig);
		write_cfg(REG_RATE_COEFF_LOW, lo);
		write_cfg(REG_RATE_COEFF_HIGH, hi);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task send_item(pump_item_t it, int gap);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.membrane_voltage <= it.v;
		item.potassium_outside <= it.ko;
		item.sodium_outside <= it.nao;
		item.sodium_inside <= it.nai;
		item.current_gain <= it.gain;
		do @(posedge clk); while (!item.ready);
	endtask

	task drain();
		item.valid <= 1'b0;
		while (sb.expected_currents.size() > 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic pump_item_t mk_item(logic [15:0] v, logic [15:0] ko, logic [15:0] nao,
			logic [15:0] nai, logic [15:0] gain);
		pump_item_t it;
		it.v = v;
		it.ko = ko;
		it.nao = nao;
		it.nai = nai;
		it.gain = gain;
		return it;
	endfunction

	function automatic pump_item_t rand_item();
		if ($urandom_range(0, 9) < 7)
			return mk_item(16'($urandom_range(0, 51200)) - 16'd25600,
				16'($urandom_range(0, 5120)), 16'($urandom_range(25600, 40960)),
				16'($urandom_range(1, 10240)), 16'($urandom_range(0, 8192)));
		return mk_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endfunction

	// nominal cell: sigma = (exp(Nao/67.3) - 1)/7, rate 1 + 0.1245 e1 + 0.0365 sigma e2
	localparam logic [63:0] SIGMA_NOM = {16'sd17229, 16'sd0, 16'sd1792, -16'sd1792};
	localparam logic [63:0] RATE_LO_NOM = {-16'sd410, 16'sd0, 16'sd510, 16'sd4096};
	localparam logic [63:0] RATE_HI_NOM = {16'sd4096, -16'sd4096, 16'sd0, 16'sd150};

	initial begin
		pump_item_t dir[$];
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_THERMAL_VOLTAGE;
		cfg_data <= '0;
		item.valid <= 1'b0;
		item.membrane_voltage <= '0;
		item.potassium_outside <= '0;
		item.sodium_outside <= '0;
		item.sodium_inside <= '0;
		item.current_gain <= '0;
		idle_cycles <= 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients still zero: zero divisor expected
		send_item(mk_item(16'h0000, 16'd1382, 16'd35840, 16'd2560, 16'd4096), 0);
		send_item(mk_item(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1);
		drain();

		write_all(16'd6838, 16'd6144, 16'd384, 16'd2560, SIGMA_NOM, RATE_LO_NOM, RATE_HI_NOM);
		dir.push_back(mk_item(16'h0000, 16'd1382, 16'd35840, 16'd2560, 16'd4096));
		dir.push_back(mk_item(16'h8000, 16'd1382, 16'd35840, 16'd2560, 16'd4096));
		dir.push_back(mk_item(16'h7FFF, 16'd1382, 16'd35840, 16'd2560, 16'd4096));
		dir.push_back(mk_item(-16'sd21760, 16'd1382, 16'd35840, 16'd2560, 16'd4096));
		dir.push_back(mk_item(16'h0000, 16'd0, 16'd35840, 16'd2560, 16'd4096));
		dir.push_back(mk_item(16'h0000, 16'hFFFF, 16'd35840, 16'd2560, 16'd4096));
		dir.push_back(mk_item(16'h0000, 16'd1382, 16'd0, 16'd2560, 16'd4096));
		dir.push_back(mk_item(16'h0000, 16'd1382, 16'hFFFF, 16'd2560, 16'd4096));
		dir.push_back(mk_item(16'h0000, 16'd1382, 16'd35840, 16'd0, 16'd4096));
		dir.push_back(mk_item(16'h0000, 16'd1382, 16'd35840, 16'd1, 16'd4096));
		dir.push_back(mk_item(16'h0000, 16'd1382, 16'd35840, 16'hFFFF, 16'd4096));
		dir.push_back(mk_item(16'h0000, 16'd1382, 16'd35840, 16'd2560, 16'd0));
		dir.push_back(mk_item(16'h0000, 16'hFFFF, 16'd35840, 16'd2560, 16'hFFFF));
		dir.push_back(mk_item(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		dir.push_back(mk_item(16'h8000, 16'd0, 16'd0, 16'd1, 16'd0));
		foreach (dir[i]) send_item(dir[i], i % 3);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			int no_gaps;
			case (ph)
				0: write_all(16'd6838, 16'd6144, 16'd384, 16'd2560,
					SIGMA_NOM, RATE_LO_NOM, RATE_HI_NOM);
				1: write_all(16'd1, 16'hFFFF, 16'd0, 16'hFFFF,
					64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
				2: write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0,
					64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_7FFF_8000_7FFF);
				3: write_all(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
					16'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom});
				default: write_all(16'($urandom_range(4000, 9000)), 16'($urandom_range(0, 16384)),
					16'($urandom_range(0, 2048)), 16'($urandom_range(0, 8192)),
					SIGMA_NOM ^ 64'($urandom_range(0, 255)),
					RATE_LO_NOM ^ 64'($urandom_range(0, 255)),
					RATE_HI_NOM ^ 64'($urandom_range(0, 255)));
			endcase
			no_gaps = $urandom_range(0, 3) == 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					drain();
				send_item(rand_item(), no_gaps ? 0 : gap_len());
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.expected_currents.size() == 0)
			$display("PASS sodium_potassium_pump_current");
		else
			$display("FAIL sodium_potassium_pump_current");
		$finish;
	end

endmodule

/* files.f */
rtl/spkp_pkg.sv
rtl/spkp_chan_if.sv
rtl/spkp_div.sv
rtl/spkp_exp.sv
rtl/sodium_potassium_pump_current.sv
tb/sv/tb_sodium_potassium_pump_current.sv
